>>> rtl/hvo_pkg.sv
// ----------------------------------------------------------------------------
// hvo_pkg
// Shared types and constants of the haversine odometer unit.
// ----------------------------------------------------------------------------
package hvo_pkg;

	localparam int COORD_W = 34;
	localparam int DIST_W  = 33;
	localparam int ODO_W   = 48;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 33;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_DEST_LAT      = 3'd0;
	localparam logic [IDX_W-1:0] REG_DEST_LONG     = 3'd1;
	localparam logic [IDX_W-1:0] REG_SPEED_LOW     = 3'd2;
	localparam logic [IDX_W-1:0] REG_SPEED_HIGH    = 3'd3;
	localparam logic [IDX_W-1:0] REG_NORM_LIMIT    = 3'd4;
	localparam logic [IDX_W-1:0] REG_ARRIVE_RADIUS = 3'd5;

	localparam logic signed [31:0] DEST_LAT_RST  = 32'sd503941040;
	localparam logic signed [32:0] DEST_LONG_RST = 33'sd524116112;
	localparam logic [15:0] SPEED_LOW_RST  = 16'd102;
	localparam logic [15:0] SPEED_HIGH_RST = 16'd1024;
	localparam logic [14:0] NORM_LIMIT_RST = 15'd307;
	localparam logic [23:0] ARRIVE_RST     = 24'd3840;

	// request to the distance engine
	typedef struct packed {
		logic start;
		logic signed [COORD_W-1:0] lat1;
		logic signed [COORD_W-1:0] lon1;
		logic signed [COORD_W-1:0] lat2;
		logic signed [COORD_W-1:0] lon2;
	} hvo_req_t;

	// status back from the distance engine
	typedef struct packed {
		logic done;
		logic [DIST_W-1:0] len;
	} hvo_resp_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_EVAL,
		T_ODO_GO,
		T_ODO_WAIT,
		T_DEST_GO,
		T_DEST_WAIT,
		T_OUT
	} hvo_top_state_t;

	typedef enum logic [3:0] {
		E_IDLE,
		E_RAD_MUL,
		E_RAD_WB,
		E_ROT_INIT,
		E_ROT,
		E_ROT_WB,
		E_P0,
		E_P1,
		E_P2,
		E_P3,
		E_P4,
		E_P5,
		E_SQA,
		E_SQB,
		E_VEC,
		E_FIN
	} hvo_eng_state_t;

endpackage

>>> rtl/hvo_dist.sv
// ----------------------------------------------------------------------------
// hvo_dist
// Iterative great-circle distance engine: one multiplier, one CORDIC step
// and one square-root step shared under a small sequencer.
// ----------------------------------------------------------------------------
module hvo_dist (
	input  logic              clk,
	input  logic              arst_n,
	input  hvo_pkg::hvo_req_t  req,
	output hvo_pkg::hvo_resp_t resp
);
	import hvo_pkg::*;

	localparam int ANG_W  = 36;
	localparam int CX_W   = 36;
	localparam int Q_W    = 33;
	localparam int MA_W   = 36;
	localparam int MB_W   = 33;
	localparam int PROD_W = MA_W + MB_W;
	localparam int SQ_W   = 63;

	localparam logic signed [MB_W-1:0] DEG_TO_RAD  = 33'sd74961321;
	localparam logic signed [MB_W-1:0] SPHERE_R    = 33'sd6372795;
	localparam logic signed [ANG_W-1:0] PI_Q30     = 36'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI    = 36'sd1686629713;
	localparam logic signed [ANG_W-1:0] TWO_PI     = 36'sd6746518852;
	localparam logic signed [CX_W-1:0] GAIN        = 36'sd652032874;
	localparam logic signed [40:0] ONE_Q30         = 41'sd1073741824;
	localparam logic [4:0] LAST_IT                 = 5'd29;

	function automatic logic signed [ANG_W-1:0] atan_step(input logic [4:0] i);
		logic signed [ANG_W-1:0] v;
		unique case (i)
			5'd0: v = 36'sd843314857;
			5'd1: v = 36'sd497837829;
			5'd2: v = 36'sd263043837;
			5'd3: v = 36'sd133525159;
			5'd4: v = 36'sd67021687;
			5'd5: v = 36'sd33543516;
			5'd6: v = 36'sd16775851;
			5'd7: v = 36'sd8388437;
			5'd8: v = 36'sd4194283;
			5'd9: v = 36'sd2097149;
			default: v = 36'sd1 <<< (6'd30 - {1'b0, i});
		endcase
		return v;
	endfunction

	hvo_eng_state_t state_q, state_d;

	logic signed [COORD_W-1:0] lat1_q, lon1_q, lat2_q, lon2_q;
	logic [1:0] idx_q;
	logic [4:0] it_q;
	logic signed [ANG_W-1:0] ang_q [4];
	logic signed [CX_W-1:0] x_q, y_q, z_q;
	logic negc_q;
	logic signed [Q_W-1:0] s1_q, s2_q, c1_q, c2_q, sq1_q, sq2_q, cc_q;
	logic [30:0] a_q;
	logic [SQ_W-1:0] n_q, r_q;
	logic [4:0] k_q;
	logic [30:0] sa_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [DIST_W-1:0] dist_q;

	// radian conversion source
	logic signed [COORD_W:0] src;
	logic src_neg;
	logic signed [MA_W-1:0] src_mag;
	always_comb begin
		unique case (idx_q)
			2'd0: src = {lat2_q[COORD_W-1], lat2_q} - {lat1_q[COORD_W-1], lat1_q};
			2'd1: src = {lon2_q[COORD_W-1], lon2_q} - {lon1_q[COORD_W-1], lon1_q};
			2'd2: src = {lat1_q[COORD_W-1], lat1_q};
			default: src = {lat2_q[COORD_W-1], lat2_q};
		endcase
		src_neg = src[COORD_W];
		src_mag = src_neg ? -MA_W'(src) : MA_W'(src);
	end

	// shared multiplier
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [Q_W:0] z_pos;
	always_comb begin
		z_pos = z_q[CX_W-1] ? '0 : (Q_W+1)'(z_q);
		mul_a = src_mag;
		mul_b = DEG_TO_RAD;
		unique case (state_q)
			E_P0: begin
				mul_a = MA_W'(s1_q);
				mul_b = s1_q;
			end
			E_P1: begin
				mul_a = MA_W'(s2_q);
				mul_b = s2_q;
			end
			E_P2: begin
				mul_a = MA_W'(c1_q);
				mul_b = c2_q;
			end
			E_P4: begin
				mul_a = MA_W'(cc_q);
				mul_b = sq2_q;
			end
			E_FIN: begin
				mul_a = MA_W'(z_pos);
				mul_b = SPHERE_R;
			end
			default: begin
				mul_a = src_mag;
				mul_b = DEG_TO_RAD;
			end
		endcase
	end

	// radian writeback: round, shift, sign, halve the deltas
	logic signed [PROD_W-1:0] rnd;
	logic signed [ANG_W-1:0] rad_mag, rad_val;
	always_comb begin
		rnd = (prod_q + PROD_W'(64'sd33554432)) >>> 26;
		rad_mag = ANG_W'(rnd);
		rad_val = src_neg ? -rad_mag : rad_mag;
		if (!idx_q[1]) begin
			rad_val = rad_val >>> 1;
		end
	end

	// angle range reduction into [-pi/2, pi/2]
	logic signed [ANG_W-1:0] red0, red1;
	logic red_neg;
	always_comb begin
		red0 = ang_q[idx_q];
		if (red0 > PI_Q30) begin
			red0 = red0 - TWO_PI;
		end else if (red0 < -PI_Q30) begin
			red0 = red0 + TWO_PI;
		end
		red1 = red0;
		red_neg = 1'b0;
		if (red0 > HALF_PI) begin
			red1 = PI_Q30 - red0;
			red_neg = 1'b1;
		end else if (red0 < -HALF_PI) begin
			red1 = -PI_Q30 - red0;
			red_neg = 1'b1;
		end
	end

	// shared cordic step, rotation or vectoring
	logic signed [CX_W-1:0] dx, dy, at, x_n, y_n, z_n;
	logic up;
	always_comb begin
		dx = y_q >>> it_q;
		dy = x_q >>> it_q;
		at = atan_step(it_q);
		up = (state_q == E_VEC) ? !(y_q > 0) : !z_q[CX_W-1];
		if (up) begin
			x_n = x_q - dx;
			y_n = y_q + dy;
			z_n = z_q - at;
		end else begin
			x_n = x_q + dx;
			y_n = y_q - dy;
			z_n = z_q + at;
		end
	end

	// shared square-root step
	logic [SQ_W-1:0] sq_bit, sq_t, n_n, r_n;
	always_comb begin
		sq_bit = SQ_W'(1) << {k_q, 1'b0};
		sq_t = r_q + sq_bit;
		if (n_q >= sq_t) begin
			n_n = n_q - sq_t;
			r_n = (r_q >> 1) + sq_bit;
		end else begin
			n_n = n_q;
			r_n = r_q >> 1;
		end
	end

	// a = sq1 + cc*sq2, clamped to [0, 1]
	logic signed [40:0] a_sum;
	logic [30:0] a_cl;
	always_comb begin
		a_sum = 41'(sq1_q) + 41'(prod_q >>> 30);
		if (a_sum[40]) begin
			a_cl = '0;
		end else if (a_sum > ONE_Q30) begin
			a_cl = 31'(ONE_Q30);
		end else begin
			a_cl = 31'(a_sum);
		end
	end

	logic [PROD_W-1:0] d_full;
	always_comb begin
		d_full = (PROD_W'(prod_q) + PROD_W'(64'd1048576)) >> 21;
	end

	logic [30:0] one_minus_a;
	assign one_minus_a = 31'(ONE_Q30) - a_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			E_IDLE: if (req.start) state_d = E_RAD_MUL;
			E_RAD_MUL: state_d = E_RAD_WB;
			E_RAD_WB: state_d = (idx_q == 2'd3) ? E_ROT_INIT : E_RAD_MUL;
			E_ROT_INIT: state_d = E_ROT;
			E_ROT: if (it_q == LAST_IT) state_d = E_ROT_WB;
			E_ROT_WB: state_d = (idx_q == 2'd3) ? E_P0 : E_ROT_INIT;
			E_P0: state_d = E_P1;
			E_P1: state_d = E_P2;
			E_P2: state_d = E_P3;
			E_P3: state_d = E_P4;
			E_P4: state_d = E_P5;
			E_P5: state_d = E_SQA;
			E_SQA: if (k_q == '0) state_d = E_SQB;
			E_SQB: if (k_q == '0) state_d = E_VEC;
			E_VEC: if (it_q == LAST_IT) state_d = E_FIN;
			E_FIN: state_d = E_IDLE;
			default: state_d = E_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			idx_q <= '0;
			it_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				E_IDLE: idx_q <= '0;
				E_RAD_WB: idx_q <= idx_q + 2'd1;
				E_ROT_INIT: it_q <= '0;
				E_ROT: it_q <= it_q + 5'd1;
				E_ROT_WB: idx_q <= idx_q + 2'd1;
				E_P5: k_q <= 5'd31;
				E_SQA: k_q <= k_q - 5'd1;
				E_SQB: begin
					k_q <= k_q - 5'd1;
					it_q <= '0;
				end
				E_VEC: it_q <= it_q + 5'd1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			E_IDLE: begin
				lat1_q <= req.lat1;
				lon1_q <= req.lon1;
				lat2_q <= req.lat2;
				lon2_q <= req.lon2;
			end
			E_RAD_WB: ang_q[idx_q] <= rad_val;
			E_ROT_INIT: begin
				x_q <= GAIN;
				y_q <= '0;
				z_q <= red1;
				negc_q <= red_neg;
			end
			E_ROT: begin
				x_q <= x_n;
				y_q <= y_n;
				z_q <= z_n;
			end
			E_ROT_WB: begin
				unique case (idx_q)
					2'd0: s1_q <= Q_W'(y_q);
					2'd1: s2_q <= Q_W'(y_q);
					2'd2: c1_q <= negc_q ? -Q_W'(x_q) : Q_W'(x_q);
					default: c2_q <= negc_q ? -Q_W'(x_q) : Q_W'(x_q);
				endcase
			end
			E_P1: sq1_q <= Q_W'(prod_q >>> 30);
			E_P2: sq2_q <= Q_W'(prod_q >>> 30);
			E_P3: cc_q <= Q_W'(prod_q >>> 30);
			E_P5: begin
				a_q <= a_cl;
				n_q <= {2'b0, a_cl, 30'b0};
				r_q <= '0;
			end
			E_SQA: begin
				if (k_q == '0) begin
					sa_q <= 31'(r_n);
					n_q <= {2'b0, one_minus_a, 30'b0};
					r_q <= '0;
				end else begin
					n_q <= n_n;
					r_q <= r_n;
				end
			end
			E_SQB: begin
				n_q <= n_n;
				r_q <= r_n;
				if (k_q == '0) begin
					x_q <= CX_W'(r_n);
					y_q <= CX_W'(sa_q);
					z_q <= '0;
				end
			end
			E_VEC: begin
				x_q <= x_n;
				y_q <= y_n;
				z_q <= z_n;
			end
			default: ;
		endcase
	end

	// final scale by the sphere radius, taken in the cycle after the product is issued
	logic fin_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= 1'b0;
		end else begin
			fin_q <= (state_q == E_FIN);
		end
	end

	always_ff @(posedge clk) begin
		if (fin_q) begin
			dist_q <= (d_full > PROD_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
				: DIST_W'(d_full);
		end
	end

	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
		end
	end

	assign resp.done = done_q;
	assign resp.len = dist_q;

endmodule

>>> rtl/haversine_odometer_unit.sv
// ----------------------------------------------------------------------------
// haversine_odometer_unit
// GPS odometer: accumulates haversine segment lengths and reports the
// distance to a configured destination.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready) carries one fix per transaction; the
//   block takes one fix at a time and drops in_ready while it works.
//   out channel (out_valid/out_ready) returns one result per fix from an
//   output register, so a new fix may be taken while a result waits.
//   cfg channel (cfg_valid/cfg_ready) writes one register per transaction,
//   cfg_ready is always high; write only while the block is idle.
// Passes: each great-circle distance runs through the shared engine
//   (4 radian products, 4 x 30 cordic rotations, the haversine products,
//   2 x 32 square-root steps, 30 cordic vectoring steps, a final scale).
//   A fix with no new segment needs one pass; a fix that adds a segment
//   needs two passes. No new fix is taken until the last fix's result
//   is in the output register.
// Reset clears position, odometer and remaining distance and loads the
//   register defaults. When the receiver stalls, a finished result holds
//   in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module haversine_odometer_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [31:0]        fix_lat,
	input  logic signed [32:0]        fix_long,
	input  logic [15:0]               fix_speed,
	input  logic signed [15:0]        norm_speed,
	input  logic                      fix_valid,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [hvo_pkg::ODO_W-1:0]  odometer,
	output logic [hvo_pkg::DIST_W-1:0] remaining,
	output logic                      arrived,
	output logic                      added,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [hvo_pkg::IDX_W-1:0]  cfg_index,
	input  logic [hvo_pkg::DATA_W-1:0] cfg_data
);
	import hvo_pkg::*;

	hvo_top_state_t state_q, state_d;

	logic signed [31:0] dest_lat_q;
	logic signed [32:0] dest_long_q;
	logic [15:0] speed_low_q, speed_high_q;
	logic [14:0] norm_limit_q;
	logic [23:0] arrive_q;

	logic signed [31:0] itm_lat_q;
	logic signed [32:0] itm_long_q;
	logic [15:0] itm_speed_q;
	logic signed [15:0] itm_norm_q;
	logic itm_valid_q;

	logic signed [COORD_W-1:0] cur_lat_q, cur_long_q, prev_lat_q, prev_long_q;
	logic [ODO_W-1:0] total_q;
	logic [DIST_W-1:0] to_dest_q, dist_dest_q;
	logic go_q, dvalid_q, added_q;
	logic out_valid_q;

	hvo_req_t req;
	hvo_resp_t resp;

	hvo_dist u_dist (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.resp(resp)
	);

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == T_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_lat_q <= DEST_LAT_RST;
			dest_long_q <= DEST_LONG_RST;
			speed_low_q <= SPEED_LOW_RST;
			speed_high_q <= SPEED_HIGH_RST;
			norm_limit_q <= NORM_LIMIT_RST;
			arrive_q <= ARRIVE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEST_LAT: dest_lat_q <= cfg_data[31:0];
				REG_DEST_LONG: dest_long_q <= cfg_data;
				REG_SPEED_LOW: speed_low_q <= cfg_data[15:0];
				REG_SPEED_HIGH: speed_high_q <= cfg_data[15:0];
				REG_NORM_LIMIT: norm_limit_q <= cfg_data[14:0];
				REG_ARRIVE_RADIUS: arrive_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// fix evaluation: seeding, movement and window checks
	logic signed [COORD_W-1:0] new_lat, new_long, np_lat, np_long;
	logic [16:0] abs_norm;
	logic go_d;
	always_comb begin
		new_lat = COORD_W'(itm_lat_q);
		new_long = COORD_W'(itm_long_q);
		if (prev_lat_q == '0 || prev_long_q == '0) begin
			np_lat = new_lat;
			np_long = new_long;
		end else begin
			np_lat = prev_lat_q;
			np_long = prev_long_q;
		end
		abs_norm = itm_norm_q[15] ? -17'(itm_norm_q) : 17'(itm_norm_q);
		go_d = itm_valid_q && new_lat != '0 && new_long != '0
			&& (np_lat != new_lat || np_long != new_long)
			&& itm_speed_q > speed_low_q && itm_speed_q < speed_high_q
			&& abs_norm < 17'(norm_limit_q);
	end

	always_comb begin
		req.start = (state_q == T_ODO_GO) || (state_q == T_DEST_GO);
		if (state_q == T_ODO_GO) begin
			req.lat1 = prev_lat_q;
			req.lon1 = prev_long_q;
			req.lat2 = cur_lat_q;
			req.lon2 = cur_long_q;
		end else begin
			req.lat1 = cur_lat_q;
			req.lon1 = cur_long_q;
			req.lat2 = COORD_W'(dest_lat_q);
			req.lon2 = COORD_W'(dest_long_q);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: if (in_valid) state_d = T_EVAL;
			T_EVAL: state_d = go_d ? T_ODO_GO : T_DEST_GO;
			T_ODO_GO: state_d = T_ODO_WAIT;
			T_ODO_WAIT: if (resp.done) state_d = T_DEST_GO;
			T_DEST_GO: state_d = T_DEST_WAIT;
			T_DEST_WAIT: if (resp.done) state_d = T_OUT;
			T_OUT: if (!out_valid_q || out_ready) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	logic [ODO_W:0] odo_sum;
	assign odo_sum = {1'b0, total_q} + (ODO_W+1)'(resp.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			cur_lat_q <= '0;
			cur_long_q <= '0;
			prev_lat_q <= '0;
			prev_long_q <= '0;
			total_q <= '0;
			dist_dest_q <= '0;
			go_q <= 1'b0;
			dvalid_q <= 1'b0;
			out_valid_q <= 1'b0;
			odometer <= '0;
			remaining <= '0;
			arrived <= 1'b0;
			added <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready && state_q != T_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_EVAL: begin
					go_q <= go_d;
					dvalid_q <= itm_valid_q && !new_lat[COORD_W-1] && new_lat != '0
						&& !new_long[COORD_W-1] && new_long != '0;
					if (itm_valid_q) begin
						cur_lat_q <= new_lat;
						cur_long_q <= new_long;
						prev_lat_q <= np_lat;
						prev_long_q <= np_long;
					end
				end
				T_ODO_WAIT: begin
					if (resp.done) begin
						total_q <= odo_sum[ODO_W] ? {ODO_W{1'b1}} : odo_sum[ODO_W-1:0];
						prev_lat_q <= cur_lat_q;
						prev_long_q <= cur_long_q;
					end
				end
				T_DEST_WAIT: begin
					if (resp.done && dvalid_q) begin
						dist_dest_q <= resp.len;
					end
				end
				T_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						odometer <= total_q;
						remaining <= dist_dest_q;
						arrived <= (to_dest_q <= DIST_W'(arrive_q));
						added <= go_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			itm_lat_q <= fix_lat;
			itm_long_q <= fix_long;
			itm_speed_q <= fix_speed;
			itm_norm_q <= norm_speed;
			itm_valid_q <= fix_valid;
		end
		if (state_q == T_DEST_WAIT && resp.done) begin
			to_dest_q <= resp.len;
		end
	end

	assign added_q = go_q;
	assign out_valid = out_valid_q;

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("block ready right after taking a fix");

	a_done_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		resp.done |-> (state_q == T_ODO_WAIT || state_q == T_DEST_WAIT))
		else $error("engine finished while sequencer not waiting");

	a_odo_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_ODO_WAIT && resp.done) |=> total_q >= $past(total_q))
		else $error("odometer decreased");

	a_added_needs_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_OUT && added_q) |-> go_q)
		else $error("segment flagged without odometer pass");

endmodule
